>>> hdl/ipc_pkg.sv
// shared types and constants for the ipv4 packet classifier
// no dependencies; used by every module of the block but ipc_checker
package ipc_pkg;

	localparam int BEAT_BITS            = 512;
	localparam int WORD_BITS            = 64;
	localparam int NUM_WORDS            = 8;
	localparam int ADDR_BITS            = 32;
	localparam int HEADER_OFFSET_BITS_DEF = 112;
	localparam int QUEUE_DEPTH_DEF      = 4;

	// header layout, bit offsets from the header start
	localparam int VERSION_POS = 4;
	localparam int PROTO_POS   = 72;
	localparam int DEST_POS    = 128;
	localparam int CSUM_WORDS  = 10;
	localparam int CSUM_HALF   = CSUM_WORDS / 2;
	localparam int HALF_SUM_BITS = 19;
	localparam int SUM_BITS    = 20;

	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [7:0] PROTO_UDP    = 8'd17;
	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic       PORT_UDP     = 1'b0;
	localparam logic       PORT_ICMP    = 1'b1;

	typedef struct packed {
		logic                 port;
		logic [BEAT_BITS-1:0] data;
		logic                 last;
	} fwd_word_t;

endpackage

>>> hdl/ipc_front.sv
// front end: header parse, checksum, route decision per frame
// depends on ipc_pkg; feeds ipc_queue
module ipc_front #(
	parameter int HEADER_OFFSET_BITS = ipc_pkg::HEADER_OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ipc_pkg::BEAT_BITS-1:0] beat,
	input  logic                          frame_end,
	input  logic [ipc_pkg::ADDR_BITS-1:0] local_address,
	output logic                          push_valid,
	output ipc_pkg::fwd_word_t            push_word,
	input  logic                          queue_full
);

	logic                               first_q;
	logic                               s1_valid_q;
	logic [ipc_pkg::BEAT_BITS-1:0]      beat_s1;
	logic                               end_s1;
	logic                               first_s1;
	logic                               ver_ok_s1;
	logic                               dest_ok_s1;
	logic [7:0]                         proto_s1;
	logic [ipc_pkg::HALF_SUM_BITS-1:0]  sum_a_s1;
	logic [ipc_pkg::HALF_SUM_BITS-1:0]  sum_b_s1;
	logic                               route_fwd_q;
	logic                               route_port_q;

	logic [ipc_pkg::HALF_SUM_BITS-1:0]  sum_a;
	logic [ipc_pkg::HALF_SUM_BITS-1:0]  sum_b;
	logic [ipc_pkg::SUM_BITS-1:0]       sum_all;
	logic [16:0]                        fold1;
	logic [16:0]                        fold2;
	logic                               csum_ok;
	logic                               proto_known;
	logic                               hdr_fwd;
	logic                               fwd;
	logic                               port;
	logic                               s1_adv;
	logic                               in_accept;

	// two partial sums of the ten header halfwords
	always_comb begin
		sum_a = '0;
		sum_b = '0;
		for (int i = 0; i < ipc_pkg::CSUM_HALF; i++) begin
			sum_a = sum_a + ipc_pkg::HALF_SUM_BITS'(beat[HEADER_OFFSET_BITS + 16*i +: 16]);
			sum_b = sum_b + ipc_pkg::HALF_SUM_BITS'(
				beat[HEADER_OFFSET_BITS + 16*(i + ipc_pkg::CSUM_HALF) +: 16]);
		end
	end

	assign in_accept = in_valid && in_ready;

	// first beat tracking depends only on frame_end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= 1'b1;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_accept)
				first_q <= frame_end;
			if (in_ready)
				s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			beat_s1    <= beat;
			end_s1     <= frame_end;
			first_s1   <= first_q;
			ver_ok_s1  <= beat[HEADER_OFFSET_BITS + ipc_pkg::VERSION_POS +: 4]
				== ipc_pkg::IPV4_VERSION;
			dest_ok_s1 <= beat[HEADER_OFFSET_BITS + ipc_pkg::DEST_POS +: ipc_pkg::ADDR_BITS]
				== local_address;
			proto_s1   <= beat[HEADER_OFFSET_BITS + ipc_pkg::PROTO_POS +: 8];
			sum_a_s1   <= sum_a;
			sum_b_s1   <= sum_b;
		end
	end

	// ones-complement fold: two end-around carries always suffice here
	assign sum_all = ipc_pkg::SUM_BITS'(sum_a_s1) + ipc_pkg::SUM_BITS'(sum_b_s1);
	assign fold1   = 17'(sum_all[15:0]) + 17'(sum_all[19:16]);
	assign fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
	assign csum_ok = fold2 == 17'h0FFFF;

	assign proto_known = (proto_s1 == ipc_pkg::PROTO_UDP) || (proto_s1 == ipc_pkg::PROTO_ICMP);
	assign hdr_fwd     = ver_ok_s1 && dest_ok_s1 && csum_ok && proto_known;
	assign fwd  = first_s1 ? hdr_fwd : route_fwd_q;
	assign port = first_s1 ? ((proto_s1 == ipc_pkg::PROTO_ICMP) ? ipc_pkg::PORT_ICMP
		: ipc_pkg::PORT_UDP) : route_port_q;

	// dropped words leave at once, forwarded ones wait for queue space
	assign s1_adv     = s1_valid_q && (!fwd || !queue_full);
	assign in_ready   = !s1_valid_q || s1_adv;
	assign push_valid = s1_valid_q && fwd && !queue_full;

	assign push_word.port = port;
	assign push_word.data = beat_s1;
	assign push_word.last = end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_fwd_q  <= 1'b0;
			route_port_q <= ipc_pkg::PORT_UDP;
		end else if (s1_adv && first_s1) begin
			route_fwd_q  <= hdr_fwd;
			route_port_q <= port;
		end
	end

endmodule

>>> hdl/ipc_queue.sv
// short word queue between the front end and the output stage
// depends on ipc_pkg
module ipc_queue #(
	parameter int DEPTH = ipc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  ipc_pkg::fwd_word_t push_word,
	output logic               full,
	output logic               pop_valid,
	output ipc_pkg::fwd_word_t pop_word,
	input  logic               pop_ready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ipc_pkg::fwd_word_t mem_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q;
	logic [AW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_word  = mem_q[rd_ptr_q];
	assign do_push   = push_valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/ipc_back.sv
// output register stage for forwarded words
// depends on ipc_pkg; drains ipc_queue
module ipc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  ipc_pkg::fwd_word_t pop_word,
	output logic               pop_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ipc_pkg::fwd_word_t out_word
);

	logic               out_valid_q;
	ipc_pkg::fwd_word_t out_word_q;
	logic               load;

	assign pop_ready = !out_valid_q || out_ready;
	assign load      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop_ready)
			out_valid_q <= pop_valid;
	end

	always_ff @(posedge clk) begin
		if (load)
			out_word_q <= pop_word;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

>>> hdl/ipv4_packet_classifier.sv
// ipv4 header check and udp/icmp demux for 512-bit frame beats
// an accepted beat passes the parse register, the queue and the output register before out_valid rises
// throughput: one beat per cycle while the queue is not full; a 4-word queue decouples the front end from the output
// dropped beats leave the parse stage without using queue space
// reset (arst_n low) empties all stages, clears local_address and waits for a first beat
// depends on ipc_pkg, ipc_front, ipc_queue, ipc_back
module ipv4_packet_classifier #(
	parameter int HEADER_OFFSET_BITS = ipc_pkg::HEADER_OFFSET_BITS_DEF,
	parameter int QUEUE_DEPTH        = ipc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] local_address,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] beat_word_0,
	input  logic [63:0] beat_word_1,
	input  logic [63:0] beat_word_2,
	input  logic [63:0] beat_word_3,
	input  logic [63:0] beat_word_4,
	input  logic [63:0] beat_word_5,
	input  logic [63:0] beat_word_6,
	input  logic [63:0] beat_word_7,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        target_port,
	output logic [63:0] out_word_0,
	output logic [63:0] out_word_1,
	output logic [63:0] out_word_2,
	output logic [63:0] out_word_3,
	output logic [63:0] out_word_4,
	output logic [63:0] out_word_5,
	output logic [63:0] out_word_6,
	output logic [63:0] out_word_7,
	output logic        out_end
);

	logic [ipc_pkg::ADDR_BITS-1:0] local_address_q;
	logic [ipc_pkg::BEAT_BITS-1:0] beat;
	logic                          push_valid;
	ipc_pkg::fwd_word_t            push_word;
	logic                          queue_full;
	logic                          pop_valid;
	ipc_pkg::fwd_word_t            pop_word;
	logic                          pop_ready;
	ipc_pkg::fwd_word_t            out_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			local_address_q <= '0;
		else if (cfg_valid)
			local_address_q <= local_address;
	end

	assign beat = {beat_word_7, beat_word_6, beat_word_5, beat_word_4,
		beat_word_3, beat_word_2, beat_word_1, beat_word_0};

	ipc_front #(
		.HEADER_OFFSET_BITS(HEADER_OFFSET_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.beat         (beat),
		.frame_end    (frame_end),
		.local_address(local_address_q),
		.push_valid   (push_valid),
		.push_word    (push_word),
		.queue_full   (queue_full)
	);

	ipc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_word (push_word),
		.full      (queue_full),
		.pop_valid (pop_valid),
		.pop_word  (pop_word),
		.pop_ready (pop_ready)
	);

	ipc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_word (pop_word),
		.pop_ready(pop_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	assign target_port = out_word.port;
	assign out_end     = out_word.last;
	assign out_word_0  = out_word.data[0*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_1  = out_word.data[1*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_2  = out_word.data[2*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_3  = out_word.data[3*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_4  = out_word.data[4*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_5  = out_word.data[5*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_6  = out_word.data[6*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];
	assign out_word_7  = out_word.data[7*ipc_pkg::WORD_BITS +: ipc_pkg::WORD_BITS];

endmodule

>>> hdl/ipc_checker.sv
// port-level checks for ipv4_packet_classifier, attached by bind
// depends only on the top level's ports
module ipc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        target_port,
	input logic        out_end,
	input logic [63:0] out_word_0
);

	logic seen_in_q;
	logic mid_frame_q;
	logic port_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q   <= 1'b0;
			mid_frame_q <= 1'b0;
			port_q      <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				seen_in_q <= 1'b1;
			if (out_valid && out_ready) begin
				mid_frame_q <= !out_end;
				port_q      <= target_port;
			end
		end
	end

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word_0)
			&& $stable(target_port) && $stable(out_end))
		else $error("output word changed while stalled");

	// every word of a frame goes to the same port
	a_port_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_frame_q |-> target_port == port_q)
		else $error("port changed inside a frame");

	// nothing comes out before any word went in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_in_q |-> !out_valid)
		else $error("output before any input");

	// reset empties the output stage
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind ipv4_packet_classifier ipc_checker u_ipc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.target_port(target_port),
	.out_end    (out_end),
	.out_word_0 (out_word_0)
);

>>> bench/ipv4_packet_classifier_tb.sv
// self-checking bench for ipv4_packet_classifier: directed frame table, then random traffic
// beats are predicted by a local header-check model and compared word by word at the output
// depends on ipc_pkg and the ipv4_packet_classifier rtl
`timescale 1ns / 1ps

module ipv4_packet_classifier_tb;

	localparam int HDR_OFF     = ipc_pkg::HEADER_OFFSET_BITS_DEF;
	localparam int HDR_BITS    = 160;
	localparam int CSUM_POS    = 80;
	localparam int SETTLE_WAIT = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 130;

	typedef enum logic [1:0] {PH_INSPECT, PH_FORWARD, PH_DISCARD} phase_t;
	typedef enum logic [1:0] {RT_UDP, RT_ICMP, RT_IGNORE} route_t;
	typedef enum logic [1:0] {ROW_FRAME, ROW_CONFIG} row_op_t;
	typedef enum logic [2:0] {
		FR_UDP, FR_ICMP, FR_OTHER, FR_BAD_VERSION, FR_BAD_DEST, FR_BAD_CSUM, FR_RAW
	} frame_kind_t;
	typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_t;
	typedef enum logic [1:0] {EXP_MODEL, EXP_DROP, EXP_UDP, EXP_ICMP} verdict_t;

	typedef struct packed {
		row_op_t     op;
		frame_kind_t kind;
		logic [3:0]  beats;
		fill_t       fill;
		verdict_t    verdict;
		logic [31:0] value;
	} row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [31:0] local_address = '0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [63:0] beat_word_0 = '0, beat_word_1 = '0, beat_word_2 = '0, beat_word_3 = '0;
	logic [63:0] beat_word_4 = '0, beat_word_5 = '0, beat_word_6 = '0, beat_word_7 = '0;
	logic        frame_end     = 1'b0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic        target_port;
	logic [63:0] out_word_0, out_word_1, out_word_2, out_word_3;
	logic [63:0] out_word_4, out_word_5, out_word_6, out_word_7;
	logic        out_end;

	ipv4_packet_classifier uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .local_address(local_address),
		.in_valid(in_valid), .in_ready(in_ready),
		.beat_word_0(beat_word_0), .beat_word_1(beat_word_1),
		.beat_word_2(beat_word_2), .beat_word_3(beat_word_3),
		.beat_word_4(beat_word_4), .beat_word_5(beat_word_5),
		.beat_word_6(beat_word_6), .beat_word_7(beat_word_7),
		.frame_end(frame_end),
		.out_valid(out_valid), .out_ready(out_ready), .target_port(target_port),
		.out_word_0(out_word_0), .out_word_1(out_word_1),
		.out_word_2(out_word_2), .out_word_3(out_word_3),
		.out_word_4(out_word_4), .out_word_5(out_word_5),
		.out_word_6(out_word_6), .out_word_7(out_word_7),
		.out_end(out_end)
	);

	// predictor state
	logic [31:0]        dev_addr = '0;
	phase_t             phase    = PH_INSPECT;
	route_t             route    = RT_IGNORE;
	ipc_pkg::fwd_word_t fwd_expected[$];

	int errors         = 0;
	int idle_cycles    = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;

	// directed frames; typed verdicts where the outcome is obvious
	row_t script [17] = '{
		'{ROW_FRAME,  FR_UDP,         4'd1, FILL_RAND, EXP_UDP,   32'h0},
		'{ROW_FRAME,  FR_ICMP,        4'd1, FILL_ONES, EXP_ICMP,  32'h0},
		'{ROW_FRAME,  FR_BAD_VERSION, 4'd1, FILL_RAND, EXP_DROP,  32'h0},
		'{ROW_FRAME,  FR_BAD_DEST,    4'd2, FILL_RAND, EXP_DROP,  32'h0},
		'{ROW_FRAME,  FR_BAD_CSUM,    4'd2, FILL_RAND, EXP_DROP,  32'h0},
		'{ROW_FRAME,  FR_OTHER,       4'd2, FILL_RAND, EXP_DROP,  32'd6},
		'{ROW_FRAME,  FR_OTHER,       4'd1, FILL_ZERO, EXP_DROP,  32'd0},
		'{ROW_FRAME,  FR_OTHER,       4'd1, FILL_ONES, EXP_DROP,  32'd255},
		'{ROW_FRAME,  FR_RAW,         4'd1, FILL_ZERO, EXP_DROP,  32'h0},
		'{ROW_FRAME,  FR_RAW,         4'd1, FILL_ONES, EXP_DROP,  32'h0},
		'{ROW_FRAME,  FR_UDP,         4'd3, FILL_ZERO, EXP_MODEL, 32'h0},
		'{ROW_FRAME,  FR_ICMP,        4'd3, FILL_ONES, EXP_MODEL, 32'h0},
		'{ROW_CONFIG, FR_RAW,         4'd0, FILL_RAND, EXP_MODEL, 32'hFFFF_FFFF},
		'{ROW_FRAME,  FR_UDP,         4'd2, FILL_ONES, EXP_MODEL, 32'h0},
		'{ROW_FRAME,  FR_BAD_DEST,    4'd1, FILL_ZERO, EXP_DROP,  32'h0},
		'{ROW_CONFIG, FR_RAW,         4'd0, FILL_RAND, EXP_MODEL, 32'h0A01_A8C0},
		'{ROW_FRAME,  FR_ICMP,        4'd2, FILL_RAND, EXP_MODEL, 32'h0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] csum_fold(input logic [HDR_BITS-1:0] h);
		logic [ipc_pkg::SUM_BITS-1:0] s;
		s = '0;
		for (int i = 0; i < ipc_pkg::CSUM_WORDS; i++)
			s += ipc_pkg::SUM_BITS'(h[16*i +: 16]);
		while (s[ipc_pkg::SUM_BITS-1:16] != 0)
			s = s[15:0] + (s >> 16);
		return s[15:0];
	endfunction

	// header check and routing for one accepted beat; returns 1 if the beat is forwarded
	function automatic bit classify_beat(input logic [ipc_pkg::BEAT_BITS-1:0] b,
			input logic eof, output logic port);
		logic [HDR_BITS-1:0] h;
		bit fwd;
		h = b[HDR_OFF +: HDR_BITS];
		fwd = 1'b0;
		port = ipc_pkg::PORT_UDP;
		if (phase == PH_INSPECT) begin
			route = RT_IGNORE;
			phase = PH_DISCARD;
			if (h[ipc_pkg::VERSION_POS +: 4] == ipc_pkg::IPV4_VERSION &&
					h[ipc_pkg::DEST_POS +: ipc_pkg::ADDR_BITS] == dev_addr &&
					csum_fold(h) == 16'hFFFF) begin
				if (h[ipc_pkg::PROTO_POS +: 8] == ipc_pkg::PROTO_UDP) begin
					route = RT_UDP;
					phase = PH_FORWARD;
				end else if (h[ipc_pkg::PROTO_POS +: 8] == ipc_pkg::PROTO_ICMP) begin
					route = RT_ICMP;
					phase = PH_FORWARD;
				end
			end
		end
		if (phase == PH_FORWARD && route != RT_IGNORE) begin
			fwd = 1'b1;
			port = (route == RT_ICMP) ? ipc_pkg::PORT_ICMP : ipc_pkg::PORT_UDP;
		end
		if (eof) begin
			phase = PH_INSPECT;
			route = RT_IGNORE;
		end
		return fwd;
	endfunction

	function automatic logic [ipc_pkg::BEAT_BITS-1:0] fill_beat(input fill_t fill);
		logic [ipc_pkg::BEAT_BITS-1:0] b;
		for (int i = 0; i < ipc_pkg::BEAT_BITS / 32; i++)
			b[32*i +: 32] = (fill == FILL_RAND) ? $urandom : (fill == FILL_ONES) ? '1 : '0;
		return b;
	endfunction

	task automatic put_beat(input logic [ipc_pkg::BEAT_BITS-1:0] b, input logic eof,
			input verdict_t verdict);
		logic port;
		bit fwd;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{beat_word_7, beat_word_6, beat_word_5, beat_word_4,
			beat_word_3, beat_word_2, beat_word_1, beat_word_0} <= b;
		frame_end <= eof;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fwd = classify_beat(b, eof, port);
		case (verdict)
			EXP_DROP: fwd = 1'b0;
			EXP_UDP: begin
				fwd = 1'b1;
				port = ipc_pkg::PORT_UDP;
			end
			EXP_ICMP: begin
				fwd = 1'b1;
				port = ipc_pkg::PORT_ICMP;
			end
			default: ;
		endcase
		if (fwd)
			fwd_expected.push_back('{port: port, data: b, last: eof});
	endtask

	task automatic send_frame(input frame_kind_t kind, input int beats, input fill_t fill,
			input verdict_t verdict, input logic [7:0] other_proto);
		logic [ipc_pkg::BEAT_BITS-1:0] b;
		logic [HDR_BITS-1:0] h;
		logic [31:0] dest;
		for (int k = 0; k < beats; k++) begin
			b = fill_beat(fill);
			if (k == 0 && kind != FR_RAW) begin
				h = HDR_BITS'(fill_beat(FILL_RAND));
				h[ipc_pkg::VERSION_POS +: 4] = ipc_pkg::IPV4_VERSION;
				h[ipc_pkg::PROTO_POS +: 8] = (kind == FR_ICMP) ? ipc_pkg::PROTO_ICMP :
					(kind == FR_OTHER) ? other_proto : ipc_pkg::PROTO_UDP;
				dest = dev_addr;
				if (kind == FR_BAD_DEST) begin
					do dest = $urandom; while (dest == dev_addr);
				end
				h[ipc_pkg::DEST_POS +: ipc_pkg::ADDR_BITS] = dest;
				if (kind == FR_BAD_VERSION) begin
					h[ipc_pkg::VERSION_POS +: 4] = 4'($urandom_range(15));
					if (h[ipc_pkg::VERSION_POS +: 4] == ipc_pkg::IPV4_VERSION)
						h[ipc_pkg::VERSION_POS +: 4] = ~ipc_pkg::IPV4_VERSION;
				end
				h[CSUM_POS +: 16] = '0;
				h[CSUM_POS +: 16] = ~csum_fold(h);
				// a single flipped bit always breaks the ones-complement sum
				if (kind == FR_BAD_CSUM)
					h[CSUM_POS + $urandom_range(15)] ^= 1'b1;
				b[HDR_OFF +: HDR_BITS] = h;
			end
			put_beat(b, k == beats - 1, verdict);
		end
	endtask

	// stop sending and let every expected word and any dropped beat leave the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		while (fwd_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_addr(input logic [31:0] addr);
		cfg_valid <= 1'b1;
		local_address <= addr;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		dev_addr = addr;
	endtask

	// receiver side: random stalls and the output check
	always @(posedge clk) begin
		ipc_pkg::fwd_word_t exp_word;
		logic [ipc_pkg::BEAT_BITS-1:0] got;
		logic [ipc_pkg::WORD_BITS-1:0] got_w;
		logic [ipc_pkg::WORD_BITS-1:0] exp_w;
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			got = {out_word_7, out_word_6, out_word_5, out_word_4,
				out_word_3, out_word_2, out_word_1, out_word_0};
			if (fwd_expected.size() == 0) begin
				$error("unexpected output word: target_port %0b out_end %0b", target_port, out_end);
				errors++;
			end else begin
				exp_word = fwd_expected.pop_front();
				if (target_port !== exp_word.port) begin
					$error("target_port: expected %0b, got %0b", exp_word.port, target_port);
					errors++;
				end
				for (int k = 0; k < ipc_pkg::NUM_WORDS; k++) begin
					got_w = got[ipc_pkg::WORD_BITS*k +: ipc_pkg::WORD_BITS];
					exp_w = exp_word.data[ipc_pkg::WORD_BITS*k +: ipc_pkg::WORD_BITS];
					if (got_w !== exp_w) begin
						$error("out_word_%0d: expected %h, got %h", k, exp_w, got_w);
						errors++;
					end
				end
				if (out_end !== exp_word.last) begin
					$error("out_end: expected %0b, got %0b", exp_word.last, out_end);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("ipv4_packet_classifier_tb failed");
			$finish;
		end
	end

	initial begin
		int phase_beats;
		int n;
		int r;
		frame_kind_t kind;
		fill_t fill;
		logic [7:0] proto;
		bit paused;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, first rows run with the address left at its reset value
		foreach (script[i]) begin
			if (script[i].op == ROW_CONFIG) begin
				settle();
				write_addr(script[i].value);
			end else begin
				send_frame(script[i].kind, int'(script[i].beats), script[i].fill,
					script[i].verdict, script[i].value[7:0]);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_addr((p == 0) ? 32'h0 : (p == 1) ? 32'hFFFF_FFFF : 32'($urandom));
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 70; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 70; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			phase_beats = 0;
			paused = 1'b0;
			while (phase_beats < PHASE_BEATS) begin
				if (p == 0 && !paused && phase_beats >= PHASE_BEATS / 2) begin
					settle();
					paused = 1'b1;
				end
				r = $urandom_range(99);
				kind = (r < 35) ? FR_UDP : (r < 70) ? FR_ICMP : (r < 76) ? FR_OTHER :
					(r < 82) ? FR_BAD_VERSION : (r < 88) ? FR_BAD_DEST :
					(r < 94) ? FR_BAD_CSUM : FR_RAW;
				r = $urandom_range(99);
				fill = (r < 90) ? FILL_RAND : (r < 95) ? FILL_ZERO : FILL_ONES;
				if (kind == FR_RAW)
					fill = FILL_RAND;
				n = ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 8);
				do proto = 8'($urandom);
				while (proto == ipc_pkg::PROTO_UDP || proto == ipc_pkg::PROTO_ICMP);
				send_frame(kind, n, fill, EXP_MODEL, proto);
				phase_beats += n;
			end
		end

		settle();
		if (errors == 0)
			$display("ipv4_packet_classifier_tb passed");
		else
			$display("ipv4_packet_classifier_tb failed");
		$finish;
	end

endmodule
